// ----- rtl/ray_sphere_intersect_top_macros.svh -----
// assertion helpers for the block's top-level rtl file
`ifndef RAY_SPHERE_INTERSECT_TOP_MACROS_SVH
`define RAY_SPHERE_INTERSECT_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RSI_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RSI_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/rsi_pkg.sv -----
`default_nettype none

package rsi_pkg;

    // default word and fraction widths of the fixed-point format
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS   = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/rsi_sqrt_pipe.sv -----
`default_nettype none

module rsi_sqrt_pipe #(
    parameter int RAD_W  = 136,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RAD_W/2-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = ROOT_W + 3;

    logic              v_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              pv;
        logic [REM_W-1:0]  prem;
        logic [ROOT_W-1:0] proot;
        logic [RAD_W-1:0]  prad;
        logic [SIDE_W-1:0] pside;
        logic [TRY_W-1:0]  rem_try;
        logic [TRY_W-1:0]  trial;
        logic [TRY_W-1:0]  diff;
        logic              fit;

        if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = in_rad;
            assign pside = in_side;
        end
        else begin : g_next
            assign pv    = v_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
            assign prad  = rad_reg[k-1];
            assign pside = side_reg[k-1];
        end

        // trial subtract of 4*root + 1
        assign rem_try = {prem, prad[RAD_W-1 -: 2]};
        assign trial   = TRY_W'({proot, 2'b01});
        assign diff    = rem_try - trial;
        assign fit     = (rem_try >= trial);

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[k] <= pv;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k]  <= fit ? diff[REM_W-1:0] : rem_try[REM_W-1:0];
                root_reg[k] <= {proot[ROOT_W-2:0], fit};
                rad_reg[k]  <= prad << 2;
                side_reg[k] <= pside;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/rsi_div_pipe.sv -----
`default_nettype none

module rsi_div_pipe #(
    parameter int NUM_W  = 67,
    parameter int QUOT_W = 31,
    parameter int FRAC_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [NUM_W-1:0]  in_den,
    input  logic              in_hit,
    output logic              out_valid,
    output logic              out_hit,
    output logic              out_sat,
    output logic [QUOT_W-1:0] out_quot
);

    localparam int EXT_W = NUM_W + FRAC_W + QUOT_W;

    logic [EXT_W-1:0]  n_ext;
    logic [EXT_W-1:0]  d_ext;

    logic              v0_reg;
    logic              hit0_reg;
    logic              sat0_reg;
    logic [NUM_W-1:0]  rem0_reg;
    logic [QUOT_W-1:0] lo0_reg;
    logic [NUM_W-1:0]  den0_reg;

    logic              v_reg    [QUOT_W];
    logic              hit_reg  [QUOT_W];
    logic              sat_reg  [QUOT_W];
    logic [NUM_W-1:0]  rem_reg  [QUOT_W];
    logic [QUOT_W-1:0] lo_reg   [QUOT_W];
    logic [NUM_W-1:0]  den_reg  [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];

    // scaled dividend and saturation test against den << QUOT_W
    assign n_ext = EXT_W'(in_num) << FRAC_W;
    assign d_ext = EXT_W'(in_den) << QUOT_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ce)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hit0_reg <= in_hit;
            sat0_reg <= (n_ext >= d_ext);
            rem0_reg <= n_ext[QUOT_W +: NUM_W];
            lo0_reg  <= n_ext[QUOT_W-1:0];
            den0_reg <= in_den;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic              pv;
        logic              phit;
        logic              psat;
        logic [NUM_W-1:0]  prem;
        logic [QUOT_W-1:0] plo;
        logic [NUM_W-1:0]  pden;
        logic [QUOT_W-1:0] pquot;
        logic [NUM_W:0]    rem_try;
        logic [NUM_W:0]    diff;
        logic              fit;

        if (k == 0) begin : g_first
            assign pv    = v0_reg;
            assign phit  = hit0_reg;
            assign psat  = sat0_reg;
            assign prem  = rem0_reg;
            assign plo   = lo0_reg;
            assign pden  = den0_reg;
            assign pquot = '0;
        end
        else begin : g_next
            assign pv    = v_reg[k-1];
            assign phit  = hit_reg[k-1];
            assign psat  = sat_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign plo   = lo_reg[k-1];
            assign pden  = den_reg[k-1];
            assign pquot = quot_reg[k-1];
        end

        assign rem_try = {prem, plo[QUOT_W-1]};
        assign diff    = rem_try - {1'b0, pden};
        assign fit     = (rem_try >= {1'b0, pden});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                hit_reg[k]  <= phit;
                sat_reg[k]  <= psat;
                rem_reg[k]  <= fit ? diff[NUM_W-1:0] : rem_try[NUM_W-1:0];
                lo_reg[k]   <= plo << 1;
                den_reg[k]  <= pden;
                quot_reg[k] <= {pquot[QUOT_W-2:0], fit};
            end
        end
    end

    assign out_valid = v_reg[QUOT_W-1];
    assign out_hit   = hit_reg[QUOT_W-1];
    assign out_sat   = sat_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/ray_sphere_intersect_top.sv -----
// Ray against sphere test, fixed point. Each ray (origin and direction, signed Q16.16 at the
// default widths) is tested against the sphere held in the centre and radius registers; every
// ray gives exactly one result: a hit flag and the nearest non-negative hit distance, unsigned
// Q15.16, saturated, zero on a miss. The block takes one ray per clock and keeps that rate for
// as long as results are taken. From acceptance to a valid result a ray passes seven stages
// that form the quadratic and its discriminant, the integer square root with one stage per
// root bit (2*WORD_BITS + 2), then one selection stage, one stage of saturation test and
// WORD_BITS - 1 stages of restoring division, and the output register. A two-entry output
// (register plus skid) lets the pipeline keep moving while one result waits. The user must write
// registers only while the block holds no ray in flight; the block itself does not enforce this.
`default_nettype none
`include "ray_sphere_intersect_top_macros.svh"

module ray_sphere_intersect_top
    import rsi_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]   cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [((6*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit, distance
    output logic [((WORD_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int W      = WORD_BITS;
    localparam int OUT_W  = ((W + 7) / 8) * 8;
    localparam int WW     = W + 1;
    localparam int P1W    = 2 * W;
    localparam int P2W    = 2 * W + 1;
    localparam int P3W    = 2 * W + 2;
    localparam int RRW    = 2 * W - 2;
    localparam int AW     = 2 * W;
    localparam int BW     = 2 * W + 3;
    localparam int CW     = 2 * W + 4;
    localparam int BMW    = 2 * W + 2;
    localparam int CMW    = 2 * W + 2;
    localparam int H      = W + 1;
    localparam int PPW    = 2 * H;
    localparam int DW     = 4 * W + 4;
    localparam int SW     = DW / 2;
    localparam int NUMW   = 2 * W + 3;
    localparam int QW     = W - 1;
    localparam int SIDE_W = 5 + AW + BMW + CMW;

    logic ce;

    // configuration registers
    logic signed [W-1:0] cx_reg;
    logic signed [W-1:0] cy_reg;
    logic signed [W-1:0] cz_reg;
    logic [W-2:0]        rad_reg;
    logic signed [W-1:0] ctr [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: cx_reg  <= cfg_data;
                CFG_CENTER_Y: cy_reg  <= cfg_data;
                CFG_CENTER_Z: cz_reg  <= cfg_data;
                CFG_RADIUS:   rad_reg <= cfg_data[W-2:0];
                default:      ;
            endcase
        end
    end

    assign ctr[0] = cx_reg;
    assign ctr[1] = cy_reg;
    assign ctr[2] = cz_reg;

    // input unpacking
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            org[i] = s_axis_tdata[i*W +: W];
            dir[i] = s_axis_tdata[(i+3)*W +: W];
        end
    end

    // stage 1: offset from the centre
    logic                 v1_reg;
    logic signed [W-1:0]  d1_reg [3];
    logic signed [WW-1:0] w1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= dir[i];
                w1_reg[i] <= WW'(org[i]) - WW'(ctr[i]);
            end
        end
    end

    // stage 2: per-axis products
    logic                  v2_reg;
    logic signed [P1W-1:0] dd2_reg [3];
    logic signed [P2W-1:0] dw2_reg [3];
    logic signed [P3W-1:0] ww2_reg [3];
    logic [RRW-1:0]        rr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd2_reg[i] <= P1W'(d1_reg[i]) * P1W'(d1_reg[i]);
                dw2_reg[i] <= P2W'(d1_reg[i]) * P2W'(w1_reg[i]);
                ww2_reg[i] <= P3W'(w1_reg[i]) * P3W'(w1_reg[i]);
            end
            rr2_reg <= RRW'(rad_reg) * RRW'(rad_reg);
        end
    end

    // stage 3: quadratic coefficients
    logic                 v3_reg;
    logic [AW-1:0]        a3_reg;
    logic signed [BW-1:0] b3_reg;
    logic signed [CW-1:0] c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a3_reg <= AW'(dd2_reg[0]) + AW'(dd2_reg[1]) + AW'(dd2_reg[2]);
            b3_reg <= BW'(dw2_reg[0]) + BW'(dw2_reg[1]) + BW'(dw2_reg[2]);
            c3_reg <= CW'(ww2_reg[0]) + CW'(ww2_reg[1]) + CW'(ww2_reg[2])
                      - CW'($signed({1'b0, rr2_reg}));
        end
    end

    // stage 4: magnitudes, flags and half-word partial products
    logic           b_neg;
    logic [BW-1:0]  b_abs;
    logic [CW-1:0]  c_abs;
    logic [BMW-1:0] bm3;
    logic [CMW-1:0] cm3;

    assign b_neg = b3_reg[BW-1];
    assign b_abs = b_neg ? (BW'(0) - b3_reg) : b3_reg;
    assign c_abs = c3_reg[CW-1] ? (CW'(0) - c3_reg) : c3_reg;
    assign bm3   = b_abs[BMW-1:0];
    assign cm3   = c_abs[CMW-1:0];

    logic           v4_reg;
    logic [PPW-1:0] bll4_reg;
    logic [PPW-1:0] blh4_reg;
    logic [PPW-1:0] bhh4_reg;
    logic [PPW-1:0] all4_reg;
    logic [PPW-1:0] alh4_reg;
    logic [PPW-1:0] ahl4_reg;
    logic [PPW-1:0] ahh4_reg;
    logic [AW-1:0]  am4_reg;
    logic [BMW-1:0] bm4_reg;
    logic [CMW-1:0] cm4_reg;
    logic           azero4_reg;
    logic           bpos4_reg;
    logic           cneg4_reg;
    logic           czero4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ce)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bll4_reg   <= PPW'(bm3[H-1:0]) * PPW'(bm3[H-1:0]);
            blh4_reg   <= PPW'(bm3[H-1:0]) * PPW'(bm3[BMW-1:H]);
            bhh4_reg   <= PPW'(bm3[BMW-1:H]) * PPW'(bm3[BMW-1:H]);
            all4_reg   <= PPW'(a3_reg[H-1:0]) * PPW'(cm3[H-1:0]);
            alh4_reg   <= PPW'(a3_reg[H-1:0]) * PPW'(cm3[CMW-1:H]);
            ahl4_reg   <= PPW'(a3_reg[AW-1:H]) * PPW'(cm3[H-1:0]);
            ahh4_reg   <= PPW'(a3_reg[AW-1:H]) * PPW'(cm3[CMW-1:H]);
            am4_reg    <= a3_reg;
            bm4_reg    <= bm3;
            cm4_reg    <= cm3;
            azero4_reg <= (a3_reg == '0);
            bpos4_reg  <= !b_neg && (b3_reg != '0);
            cneg4_reg  <= c3_reg[CW-1];
            czero4_reg <= (c3_reg == '0);
        end
    end

    // stage 5: B squared, middle terms of A*|C|
    logic           v5_reg;
    logic [DW-1:0]  b25_reg;
    logic [PPW:0]   acm5_reg;
    logic [PPW-1:0] all5_reg;
    logic [PPW-1:0] ahh5_reg;
    logic [AW-1:0]  am5_reg;
    logic [BMW-1:0] bm5_reg;
    logic [CMW-1:0] cm5_reg;
    logic           azero5_reg;
    logic           bpos5_reg;
    logic           cneg5_reg;
    logic           czero5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (ce)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b25_reg    <= (DW'(bhh4_reg) << (2 * H)) + (DW'(blh4_reg) << (H + 1))
                          + DW'(bll4_reg);
            acm5_reg   <= (PPW + 1)'(alh4_reg) + (PPW + 1)'(ahl4_reg);
            all5_reg   <= all4_reg;
            ahh5_reg   <= ahh4_reg;
            am5_reg    <= am4_reg;
            bm5_reg    <= bm4_reg;
            cm5_reg    <= cm4_reg;
            azero5_reg <= azero4_reg;
            bpos5_reg  <= bpos4_reg;
            cneg5_reg  <= cneg4_reg;
            czero5_reg <= czero4_reg;
        end
    end

    // stage 6: A*|C|
    logic           v6_reg;
    logic [DW-1:0]  b26_reg;
    logic [DW-1:0]  ac6_reg;
    logic [AW-1:0]  am6_reg;
    logic [BMW-1:0] bm6_reg;
    logic [CMW-1:0] cm6_reg;
    logic           azero6_reg;
    logic           bpos6_reg;
    logic           cneg6_reg;
    logic           czero6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (ce)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b26_reg    <= b25_reg;
            ac6_reg    <= (DW'(ahh5_reg) << (2 * H)) + (DW'(acm5_reg) << H) + DW'(all5_reg);
            am6_reg    <= am5_reg;
            bm6_reg    <= bm5_reg;
            cm6_reg    <= cm5_reg;
            azero6_reg <= azero5_reg;
            bpos6_reg  <= bpos5_reg;
            cneg6_reg  <= cneg5_reg;
            czero6_reg <= czero5_reg;
        end
    end

    // stage 7: discriminant, miss and tangent flags
    logic [DW-1:0] d_val;

    assign d_val = cneg6_reg ? (b26_reg + ac6_reg) : (b26_reg - ac6_reg);

    logic              v7_reg;
    logic [DW-1:0]     d7_reg;
    logic [SIDE_W-1:0] side7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (ce)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d7_reg    <= d_val;
            side7_reg <= {azero6_reg || d_val[DW-1], (d_val == '0), bpos6_reg,
                          cneg6_reg, czero6_reg, am6_reg, bm6_reg, cm6_reg};
        end
    end

    // integer square root of the discriminant
    logic              sq_valid;
    logic [SW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    rsi_sqrt_pipe #(
        .RAD_W  (DW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v7_reg),
        .in_rad    (d7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // root choice: numerator and denominator of the reported distance
    logic           s_miss;
    logic           s_tan;
    logic           s_bpos;
    logic           s_cneg;
    logic           s_czero;
    logic [AW-1:0]  s_am;
    logic [BMW-1:0] s_bm;
    logic [CMW-1:0] s_cm;
    logic [NUMW-1:0] den_q;
    logic            miss_sel;
    logic [NUMW-1:0] num_sel;
    logic [NUMW-1:0] den_sel;

    assign {s_miss, s_tan, s_bpos, s_cneg, s_czero, s_am, s_bm, s_cm} = sq_side;
    assign den_q = NUMW'(s_bm) + NUMW'(sq_root);

    always_comb
    begin
        miss_sel = s_miss;
        num_sel  = NUMW'(s_cm);
        den_sel  = den_q;
        if (s_tan)
        begin
            // tangent ray: single root -B/A
            miss_sel = s_miss || s_bpos;
            num_sel  = NUMW'(s_bm);
            den_sel  = NUMW'(s_am);
        end
        else if (s_bpos)
        begin
            miss_sel = s_miss || (!s_cneg && !s_czero);
        end
        else if (s_cneg)
        begin
            num_sel = den_q;
            den_sel = NUMW'(s_am);
        end
    end

    logic            v8_reg;
    logic            hit8_reg;
    logic [NUMW-1:0] num8_reg;
    logic [NUMW-1:0] den8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (ce)
        begin
            v8_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hit8_reg <= !miss_sel;
            num8_reg <= num_sel;
            den8_reg <= den_sel;
        end
    end

    // scaled quotient with saturation
    logic          dv_valid;
    logic          dv_hit;
    logic          dv_sat;
    logic [QW-1:0] dv_quot;
    logic [QW-1:0] res_dist;

    rsi_div_pipe #(
        .NUM_W  (NUMW),
        .QUOT_W (QW),
        .FRAC_W (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v8_reg),
        .in_num    (num8_reg),
        .in_den    (den8_reg),
        .in_hit    (hit8_reg),
        .out_valid (dv_valid),
        .out_hit   (dv_hit),
        .out_sat   (dv_sat),
        .out_quot  (dv_quot)
    );

    assign res_dist = !dv_hit ? '0 : (dv_sat ? '1 : dv_quot);

    // output register with skid entry
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [QW-1:0] out_dist_reg;
    logic          skid_valid_reg;
    logic          skid_hit_reg;
    logic [QW-1:0] skid_dist_reg;
    logic          out_load;

    assign out_load = !out_valid_reg || m_axis_tready;
    assign ce       = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || dv_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (ce && dv_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg  <= skid_valid_reg ? skid_hit_reg : dv_hit;
            out_dist_reg <= skid_valid_reg ? skid_dist_reg : res_dist;
        end
        else if (ce && dv_valid)
        begin
            skid_hit_reg  <= dv_hit;
            skid_dist_reg <= res_dist;
        end
    end

    assign s_axis_tready = ce;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_dist_reg, out_hit_reg});

    // checks
    `RSI_ASSERT_IMP(a_skid_has_out, skid_valid_reg, out_valid_reg, "skid full without output")
    `RSI_ASSERT_IMP(a_miss_zero, out_valid_reg && !out_hit_reg, out_dist_reg == '0,
        "miss with non-zero distance")
    `RSI_ASSERT_NXT(a_stall_to_skid, out_valid_reg && !m_axis_tready && ce && dv_valid,
        skid_valid_reg, "result lost on stall")
    `RSI_ASSERT_NXT(a_hold_on_stall, !ce, $stable(dv_valid), "pipeline moved while stalled")

endmodule

`default_nettype wire
